@@ rtl/calendar_date_step_counter_unit_assert.svh @@
// Assertion macros shared by the calendar day counter RTL.
`ifndef CALENDAR_DATE_STEP_COUNTER_UNIT_ASSERT_SVH
`define CALENDAR_DATE_STEP_COUNTER_UNIT_ASSERT_SVH

// Check a property on the rising edge, ignored while reset is low.
`define CDSC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on the rising edge, reset cycles included.
`define CDSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/cdsc_pkg.sv @@
// Types, codes and month table for the calendar day counter.
package cdsc_pkg;

    typedef logic [1:0] t_op;
    typedef logic [1:0] t_status;

    localparam t_op OP_FWD  = 2'd0;
    localparam t_op OP_BACK = 2'd1;
    localparam t_op OP_LOAD = 2'd2;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_BAD_LOAD = 2'd1;
    localparam t_status ST_LIMIT    = 2'd2;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    localparam logic [4:0] DAY_FIRST = 5'd1;
    localparam logic [4:0] DAY_LAST_DEC = 5'd31;

    // Multiplicative inverse of an odd number modulo 2^32 (Newton steps)
    function automatic logic [31:0] inv_odd(input logic [31:0] d);
        logic [31:0] x;
        x = d;
        for (int k = 0; k < 5; k++) begin
            x = x * (32'd2 - d * x);
        end
        return x;
    endfunction

    localparam logic [31:0] INV25 = inv_odd(32'd25);

    // Days in a month, given the leap flag of its year
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m) inside
            MONTH_FEB:                 len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

@@ rtl/cdsc_leap.sv @@
// Gregorian leap-year test for one year value.
module cdsc_leap
    import cdsc_pkg::*;
#(
    parameter int YEAR_BITS = 14
) (
    input  logic [YEAR_BITS-1:0] i_year,
    output logic                 o_leap
);

    localparam logic [YEAR_BITS-1:0] Inv = INV25[YEAR_BITS-1:0];
    localparam int unsigned ThrInt = ((2 ** YEAR_BITS) - 1) / 25;
    localparam logic [YEAR_BITS-1:0] Thr = ThrInt[YEAR_BITS-1:0];

    logic [YEAR_BITS-1:0] w_prod;
    logic                 w_div25;

    // Divisible by 25 when the product with the inverse lands in the low range
    assign w_prod  = i_year * Inv;
    assign w_div25 = (w_prod <= Thr);

    // By 4, and not by 100 unless by 400 (by 100 = by 4 and 25, by 400 = by 16 and 25)
    assign o_leap = (i_year[1:0] == 2'd0) && (!w_div25 || (i_year[3:0] == 4'd0));

endmodule

@@ rtl/cdsc_step.sv @@
// Next-date logic: one day forward, one day back, or a checked load.
module cdsc_step
    import cdsc_pkg::*;
#(
    parameter int YEAR_BITS = 14
) (
    input  t_op                  i_op,
    input  logic [4:0]           i_load_day,
    input  logic [3:0]           i_load_month,
    input  logic [YEAR_BITS-1:0] i_load_year,
    input  logic [4:0]           i_day,
    input  logic [3:0]           i_month,
    input  logic [YEAR_BITS-1:0] i_year,
    input  logic                 i_leap,
    input  logic                 i_leap_next,
    input  logic                 i_leap_prev,
    input  logic                 i_leap_load,
    output logic [4:0]           o_day,
    output logic [3:0]           o_month,
    output logic [YEAR_BITS-1:0] o_year,
    output logic                 o_leap,
    output t_status              o_status
);

    logic [3:0] w_month_prev;
    logic       w_load_ok;

    assign w_month_prev = i_month - 4'd1;

    // Accept a load only if it names a real date
    assign w_load_ok = (i_load_month >= MONTH_JAN) && (i_load_month <= MONTH_DEC) &&
                       (i_load_day >= DAY_FIRST) &&
                       (i_load_day <= month_len(i_load_month, i_leap_load));

    // Decode the operation and roll over at month and year ends
    always_comb begin
        o_day    = i_day;
        o_month  = i_month;
        o_year   = i_year;
        o_leap   = i_leap;
        o_status = ST_OK;
        unique case (i_op)
            OP_FWD: begin
                if (i_day < month_len(i_month, i_leap)) begin
                    o_day = i_day + 5'd1;
                end else if (i_month < MONTH_DEC) begin
                    o_day   = DAY_FIRST;
                    o_month = i_month + 4'd1;
                end else if (i_year != {YEAR_BITS{1'b1}}) begin
                    o_day   = DAY_FIRST;
                    o_month = MONTH_JAN;
                    o_year  = i_year + YEAR_BITS'(1);
                    o_leap  = i_leap_next;
                end else begin
                    o_status = ST_LIMIT;
                end
            end
            OP_BACK: begin
                if (i_day > DAY_FIRST) begin
                    o_day = i_day - 5'd1;
                end else if (i_month > MONTH_JAN) begin
                    o_month = w_month_prev;
                    o_day   = month_len(w_month_prev, i_leap);
                end else if (i_year != '0) begin
                    o_year  = i_year - YEAR_BITS'(1);
                    o_month = MONTH_DEC;
                    o_day   = DAY_LAST_DEC;
                    o_leap  = i_leap_prev;
                end else begin
                    o_status = ST_LIMIT;
                end
            end
            OP_LOAD: begin
                if (w_load_ok) begin
                    o_day   = i_load_day;
                    o_month = i_load_month;
                    o_year  = i_load_year;
                    o_leap  = i_leap_load;
                end else begin
                    o_status = ST_BAD_LOAD;
                end
            end
            default: begin
                o_status = ST_OK;
            end
        endcase
    end

endmodule

@@ rtl/calendar_date_step_counter_unit.sv @@
// Top level of the Gregorian calendar day counter.
//
//   channel  | handshake          | word
//   ---------+--------------------+---------------------------------------------
//   in       | i_valid / o_ready  | i_op, i_load_day, i_load_month, i_load_year
//   out      | o_valid / i_ready  | o_cur_day, o_cur_month, o_cur_year,
//            |                    | o_leap_flag, o_status
//
// One word per cycle sustained while i_ready stays high; an accepted word
// passes through the input register, then the date and status registers.
// The next-date logic and three leap tests sit between the input register and
// the date registers. Reset sets 1 January of year 0 and empties both stages.
// A stalled output holds its word while one more input word waits in the
// input register.
module calendar_date_step_counter_unit
    import cdsc_pkg::*;
#(
    parameter int YEAR_BITS = 14
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_op,
    input  logic [4:0]           i_load_day,
    input  logic [3:0]           i_load_month,
    input  logic [YEAR_BITS-1:0] i_load_year,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [4:0]           o_cur_day,
    output logic [3:0]           o_cur_month,
    output logic [YEAR_BITS-1:0] o_cur_year,
    output logic                 o_leap_flag,
    output logic [1:0]           o_status
);

`include "calendar_date_step_counter_unit_assert.svh"

    // Input register
    logic                 r_in_valid;
    t_op                  r_op;
    logic [4:0]           r_load_day;
    logic [3:0]           r_load_month;
    logic [YEAR_BITS-1:0] r_load_year;

    // Date state, doubles as the output word
    logic                 r_out_valid;
    logic [4:0]           r_day;
    logic [3:0]           r_month;
    logic [YEAR_BITS-1:0] r_year;
    logic                 r_leap;
    t_status              r_status;

    logic [4:0]           n_day;
    logic [3:0]           n_month;
    logic [YEAR_BITS-1:0] n_year;
    logic                 n_leap;
    t_status              n_status;

    logic                 w_adv;
    logic                 w_in_ready;
    logic                 w_leap_next;
    logic                 w_leap_prev;
    logic                 w_leap_load;
    logic [YEAR_BITS-1:0] w_year_next;
    logic [YEAR_BITS-1:0] w_year_prev;

    // Move a word into the date registers when the output slot frees up
    assign w_adv      = r_in_valid && (!r_out_valid || i_ready);
    assign w_in_ready = !r_in_valid || w_adv;
    assign o_ready    = w_in_ready;

    assign w_year_next = r_year + YEAR_BITS'(1);
    assign w_year_prev = r_year - YEAR_BITS'(1);

    cdsc_leap #(.YEAR_BITS(YEAR_BITS)) u_leap_next (
        .i_year (w_year_next),
        .o_leap (w_leap_next)
    );

    cdsc_leap #(.YEAR_BITS(YEAR_BITS)) u_leap_prev (
        .i_year (w_year_prev),
        .o_leap (w_leap_prev)
    );

    cdsc_leap #(.YEAR_BITS(YEAR_BITS)) u_leap_load (
        .i_year (r_load_year),
        .o_leap (w_leap_load)
    );

    cdsc_step #(.YEAR_BITS(YEAR_BITS)) u_step (
        .i_op         (r_op),
        .i_load_day   (r_load_day),
        .i_load_month (r_load_month),
        .i_load_year  (r_load_year),
        .i_day        (r_day),
        .i_month      (r_month),
        .i_year       (r_year),
        .i_leap       (r_leap),
        .i_leap_next  (w_leap_next),
        .i_leap_prev  (w_leap_prev),
        .i_leap_load  (w_leap_load),
        .o_day        (n_day),
        .o_month      (n_month),
        .o_year       (n_year),
        .o_leap       (n_leap),
        .o_status     (n_status)
    );

    // Control and date state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_day       <= DAY_FIRST;
            r_month     <= MONTH_JAN;
            r_year      <= '0;
            r_leap      <= 1'b1;
        end else begin
            if (w_in_ready) begin
                r_in_valid <= i_valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_day       <= n_day;
                r_month     <= n_month;
                r_year      <= n_year;
                r_leap      <= n_leap;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the input word and the result status
    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_valid) begin
            r_op         <= i_op;
            r_load_day   <= i_load_day;
            r_load_month <= i_load_month;
            r_load_year  <= i_load_year;
        end
        if (w_adv) begin
            r_status <= n_status;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_cur_day   = r_day;
    assign o_cur_month = r_month;
    assign o_cur_year  = r_year;
    assign o_leap_flag = r_leap;
    assign o_status    = r_status;

    // Checks
    `CDSC_ASSERT_ALWAYS(a_reset_date, i_clk,
        !i_rst_n |=> (r_day == DAY_FIRST && r_month == MONTH_JAN && r_year == '0 && r_leap),
        "reset date is not 1 January of year 0")
    `CDSC_ASSERT(a_valid_date, i_clk, i_rst_n,
        (r_month >= MONTH_JAN && r_month <= MONTH_DEC && r_day >= DAY_FIRST &&
         r_day <= month_len(r_month, r_leap)),
        "stored date is not a real date")
    `CDSC_ASSERT(a_hold_on_fault, i_clk, i_rst_n,
        (w_adv && n_status != ST_OK) |=>
            ($stable(r_day) && $stable(r_month) && $stable(r_year)),
        "date changed on a refused word")

endmodule
